/* design/cfb_pkg.sv */
// Shared types and constants of the Caesar shift frequency breaker.
`timescale 1ns / 1ps
package cfb_pkg;

    localparam int NUM_LETTERS = 26;

    // English letter frequencies in units of 1e-5, a through z.
    localparam int unsigned ENG_FREQ_E5 [NUM_LETTERS] = '{
        8200, 1500, 2800, 4300, 13000, 2200, 2000, 6100, 7000, 150,
        770, 4000, 2400, 6700, 7500, 1900, 95, 6000, 6300, 9100,
        2800, 980, 2400, 150, 2000, 74
    };

    localparam logic [7:0]  CHAR_A      = 8'h61;
    localparam logic [7:0]  CHAR_Z      = 8'h7A;
    localparam logic [4:0]  LAST_LETTER = 5'd25;
    localparam logic [4:0]  BUBBLE_STEP = 5'd26;
    localparam logic [4:0]  FIRST_SHIFT = 5'd1;
    localparam logic [4:0]  LAST_SHIFT  = 5'd26;
    localparam logic [62:0] SAT63       = {63{1'b1}};
    localparam logic [63:0] SQRT_LIMIT  = 64'd3037000499;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_SCORE,
        ST_DRAIN
    } cfb_state_t;

    // One scoring step handed to the score pipeline.
    typedef struct packed {
        logic       valid;
        logic [4:0] shift;
        logic [4:0] letter;
    } cfb_step_t;

    // Final answer of the score pipeline.
    typedef struct packed {
        logic        valid;
        logic [4:0]  shift;
        logic [62:0] score;
    } cfb_result_t;

endpackage

/* design/cfb_in_if.sv */
// Input channel: ciphertext bytes with a last flag.
`timescale 1ns / 1ps
interface cfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

/* design/cfb_out_if.sv */
// Output channel: the winning shift, its score and the overflow flag.
`timescale 1ns / 1ps
interface cfb_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  best_shift;
    logic [62:0] best_score;
    logic        length_overflow;

    modport source (output valid, output best_shift, output best_score,
                    output length_overflow, input ready);
    modport sink   (input valid, input best_shift, input best_score,
                    input length_overflow, output ready);
endinterface

/* design/cfb_count_cell.sv */
// One histogram cell of the letter-count ring.
`timescale 1ns / 1ps
module cfb_count_cell #(
    parameter int CW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          rotate,
    input  logic          inc,
    input  logic [CW-1:0] shift_in,
    output logic [CW-1:0] count
);
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Clearing wins, then the ring shift, then counting a letter.
    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (rotate)
        begin
            count_next = shift_in;
        end
        else if (inc)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
endmodule

/* design/cfb_score_unit.sv */
// Pipelined squared-distance scorer with running minimum over shifts.
`timescale 1ns / 1ps
module cfb_score_unit #(
    parameter int CW                 = 16,
    parameter int FREQ_FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfb_pkg::cfb_step_t   step,
    input  logic [CW-1:0]        count,
    input  logic [CW-1:0]        text_len,
    output cfb_pkg::cfb_result_t result
);
    import cfb_pkg::*;

    localparam int FW = FREQ_FRACTION_BITS;
    localparam int AW = CW + FW;

    logic [FW-1:0] freq_tab [NUM_LETTERS];

    // Fixed-point English frequencies, rounded half up.
    for (genvar g = 0; g < NUM_LETTERS; g++)
    begin : g_freq
        localparam logic [63:0] FQ =
            ((64'(ENG_FREQ_E5[g]) << FREQ_FRACTION_BITS) + 64'd50000) / 64'd100000;
        assign freq_tab[g] = FQ[FW-1:0];
    end

    cfb_step_t     s1_tag_reg;
    logic [AW-1:0] s1_a_reg;
    logic [AW-1:0] s1_b_reg;
    cfb_step_t     s2_tag_reg;
    logic [63:0]   s2_d_reg;
    logic          s2_sat_reg;
    cfb_step_t     s3_tag_reg;
    logic [63:0]   s3_sq_reg;
    logic          s3_sat_reg;
    logic [62:0]   acc_reg;
    logic [62:0]   best_score_reg;
    logic [4:0]    best_shift_reg;
    logic          done_reg;

    logic [AW-1:0] diff;
    logic [63:0]   diff64;
    logic [62:0]   acc_base;
    logic [64:0]   acc_sum;
    logic [62:0]   acc_next;
    logic          take_best;

    // Stage 1: scaled count and expected count.
    always_ff @(posedge clk)
    begin
        s1_a_reg <= {count, FW'(0)};
        s1_b_reg <= AW'(freq_tab[step.letter] * text_len);
    end

    // Stage 2: absolute difference and saturation check.
    assign diff   = (s1_a_reg > s1_b_reg) ? (s1_a_reg - s1_b_reg) : (s1_b_reg - s1_a_reg);
    assign diff64 = 64'(diff);

    always_ff @(posedge clk)
    begin
        s2_d_reg   <= diff64;
        s2_sat_reg <= diff64 > SQRT_LIMIT;
    end

    // Stage 3: one 32 by 32 square.
    always_ff @(posedge clk)
    begin
        s3_sq_reg  <= s2_d_reg[31:0] * s2_d_reg[31:0];
        s3_sat_reg <= s2_sat_reg;
    end

    // Stage 4: saturating accumulation and minimum tracking.
    assign acc_base = (s3_tag_reg.letter == '0) ? '0 : acc_reg;
    assign acc_sum  = 65'(acc_base) + 65'(s3_sq_reg);
    assign acc_next = (s3_sat_reg || acc_sum > 65'(SAT63)) ? SAT63 : acc_sum[62:0];
    assign take_best = (s3_tag_reg.shift == FIRST_SHIFT) || (acc_next < best_score_reg);

    always_ff @(posedge clk)
    begin
        if (s3_tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (s3_tag_reg.valid && s3_tag_reg.letter == LAST_LETTER && take_best)
        begin
            best_score_reg <= acc_next;
            best_shift_reg <= s3_tag_reg.shift;
        end
    end

    // Tags of the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_tag_reg <= step;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            done_reg   <= s3_tag_reg.valid && s3_tag_reg.letter == LAST_LETTER
                          && s3_tag_reg.shift == LAST_SHIFT;
        end
    end

    assign result.valid = done_reg;
    assign result.shift = best_shift_reg;
    assign result.score = best_score_reg;
endmodule

/* design/caesar_shift_frequency_breaker_unit.sv */
// Top level: letter-count ring, scoring sequencer and result register.
// Bytes are taken one item a cycle while they arrive; after the last byte the ring
// turns through 26 shifts, each a bubble step and one step per letter, and the
// result is set by the single squaring pipeline and the rotating ring.
// Input is held off from the last byte until the result is registered.
// Reset clears counts, length, overflow flag, state and the output valid flag.
`timescale 1ns / 1ps
module caesar_shift_frequency_breaker_unit #(
    parameter int MAX_TEXT_LENGTH    = 65535,
    parameter int FREQ_FRACTION_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    cfb_in_if.sink    text,
    cfb_out_if.source result
);
    import cfb_pkg::*;

    localparam int CW = $clog2(MAX_TEXT_LENGTH + 1);

    cfb_state_t    state_reg;
    cfb_state_t    state_next;
    logic [4:0]    shift_reg;
    logic [4:0]    shift_next;
    logic [4:0]    step_reg;
    logic [4:0]    step_next;
    logic [CW-1:0] len_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    logic [4:0]    out_shift_reg;
    logic [62:0]   out_score_reg;
    logic          out_ovf_reg;

    logic          accept;
    logic          at_limit;
    logic          is_letter;
    logic [4:0]    letter_idx;
    logic          rotate;
    logic          clear;
    logic [CW-1:0] counts [NUM_LETTERS];
    cfb_step_t     step;
    cfb_result_t   res;

    assign accept     = text.valid && text.ready;
    assign at_limit   = len_reg >= CW'(MAX_TEXT_LENGTH);
    assign is_letter  = text.text_byte >= CHAR_A && text.text_byte <= CHAR_Z;
    assign letter_idx = 5'(text.text_byte - CHAR_A);
    assign clear      = res.valid;

    // Ring of count cells; cell k takes its neighbor k+1 on a turn.
    for (genvar k = 0; k < NUM_LETTERS; k++)
    begin : g_cell
        cfb_count_cell #(.CW(CW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear),
            .rotate   (rotate),
            .inc      (accept && !at_limit && is_letter && letter_idx == 5'(k)),
            .shift_in (counts[(k + 1) % NUM_LETTERS]),
            .count    (counts[k])
        );
    end

    cfb_score_unit #(.CW(CW), .FREQ_FRACTION_BITS(FREQ_FRACTION_BITS)) u_score (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .count    (counts[0]),
        .text_len (len_reg),
        .result   (res)
    );

    // Sequencer next state and outputs.
    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        step_next  = step_reg;
        rotate     = 1'b0;
        step.valid = 1'b0;
        step.shift = shift_reg;
        step.letter = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && text.last_byte)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                shift_next = '0;
                step_next  = BUBBLE_STEP;
                if (!out_valid_reg)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                rotate     = 1'b1;
                step.valid = step_reg != BUBBLE_STEP;
                if (step_reg == BUBBLE_STEP)
                begin
                    step_next  = '0;
                    shift_next = shift_reg + 5'd1;
                end
                else if (shift_reg == LAST_SHIFT && step_reg == LAST_LETTER)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DRAIN:
            begin
                if (res.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            step_reg  <= step_next;
        end
    end

    // Text length and overflow tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (clear)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (at_limit)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                len_reg <= len_reg + CW'(1);
            end
        end
    end

    // Output register holding one result item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_shift_reg <= res.shift;
            out_score_reg <= res.score;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign text.ready             = state_reg == ST_IDLE;
    assign result.valid           = out_valid_reg;
    assign result.best_shift      = out_shift_reg;
    assign result.best_score      = out_score_reg;
    assign result.length_overflow = out_ovf_reg;
endmodule

/* design/cfb_checker.sv */
// Port-level checks of the breaker and their binding to the top level.
`timescale 1ns / 1ps
module cfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_shift
);
    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_shift))
        else $error("result item changed while stalled");

    // The winning shift is always a real shift.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_shift >= 5'd1 && out_shift <= 5'd26)
        else $error("shift out of range");

    // Input closes right after the last byte of a text.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input open after last byte");

    // A new result only appears at the end of a scoring pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without scoring pass");
endmodule

bind caesar_shift_frequency_breaker_unit cfb_checker u_cfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .in_last   (text.last_byte),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_shift (result.best_shift)
);
